// ----- rtl/core/rbf_pkg.sv -----
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared types and codes for the ring-buffer FIFO with block operations.
// ----------------------------------------------------------------------------
package rbf_pkg;

  // Fixed field widths of the block's ports
  localparam int OP_W     = 3;
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;

  // Operation codes carried by in_op
  typedef enum logic [OP_W-1:0] {
    OP_WRITE     = 3'd0,
    OP_BLK_HEAD  = 3'd1,
    OP_BLK_DATA  = 3'd2,
    OP_READ      = 3'd3,
    OP_READ_BLK  = 3'd4
  } op_t;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NOROOM    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_SHORT     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_OVERWROTE = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_DISCARD   = 3'd4;

  // Commands from controller to datapath
  typedef struct packed {
    logic exec;       // execute the op on the input ports this cycle
    logic read_step;  // pop one element and emit it
    logic cfg_write;  // take a capacity write
  } rbf_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic read_go;    // the op on the input ports starts a read sequence
    logic read_last;  // the current read step is the final one
  } rbf_stat_t;

endpackage

// ----- rtl/core/ring_buffer_fifo_with_block_ops_top.sv -----
// ----------------------------------------------------------------------------
// ring_buffer_fifo_with_block_ops_top
// Ring-buffer FIFO with single and block writes and reads.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start/in_op/in_count/in_data and are taken when start is
//   high and busy is low. Results leave on the out_ ports for one cycle each,
//   flagged by out_valid; the receiver must take every beat as it comes.
//   Capacity is written through cfg_valid/cfg_ready/cfg_data while idle, and
//   each write empties the FIFO (slot contents are kept).
// Throughput and read sequencing:
//   Writes, block heads, block data, failed or empty reads and unknown ops answer in
//   the cycle after acceptance and never raise busy, so one command per cycle.
//   A read raises busy while the sequencer pops one slot per cycle through
//   the memory's single read port; the beats come from the registered read
//   data, one per cycle. The next command can be taken in the cycle that
//   shows the last beat.
// Reset:
//   Synchronous, active low. Pointers, counts and block state clear, capacity
//   returns to DEPTH. The slot memory is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module ring_buffer_fifo_with_block_ops_top #(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [rbf_pkg::OP_W-1:0]        in_op,
  input  logic [rbf_pkg::CNT_W-1:0]       in_count,
  input  logic [rbf_pkg::DATA_W-1:0]      in_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rbf_pkg::CNT_W-1:0]       cfg_data,
  output logic                            out_valid,
  output logic [rbf_pkg::STATUS_W-1:0]    out_status,
  output logic [rbf_pkg::DATA_W-1:0]      out_read_data,
  output logic                            out_last,
  output logic [rbf_pkg::CNT_W-1:0]       out_used_count,
  output logic [rbf_pkg::CNT_W-1:0]       out_free_count
);
  import rbf_pkg::*;

  rbf_cmd_t  cmd;
  rbf_stat_t stat;

  // Sequencer
  rbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_valid (cfg_valid),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_ready (cfg_ready)
  );

  // Storage and arithmetic
  rbf_dpath #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_op          (in_op),
    .in_count       (in_count),
    .in_data        (in_data),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_read_data  (out_read_data),
    .out_last       (out_last),
    .out_used_count (out_used_count),
    .out_free_count (out_free_count)
  );

endmodule

// ----- rtl/core/rbf_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbf_ctrl
// Sequencer: accepts commands when idle and walks through read sequences.
// ----------------------------------------------------------------------------
module rbf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              cfg_valid,
  input  rbf_pkg::rbf_stat_t stat,
  output rbf_pkg::rbf_cmd_t  cmd,
  output logic              busy,
  output logic              cfg_ready
);
  import rbf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Decode commands from the current state; hold off capacity writes
  // while a command is offered so the two never share a cycle
  always_comb begin
    cmd.exec      = (state_r == ST_IDLE) && start;
    cmd.read_step = (state_r == ST_READ);
    cmd.cfg_write = (state_r == ST_IDLE) && !start && cfg_valid;
    busy          = (state_r != ST_IDLE);
    cfg_ready     = (state_r == ST_IDLE) && !start;
  end

  // Enter the read loop on a successful read, leave after the last read step
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.exec && stat.read_go) state_nxt = ST_READ;
      end
      ST_READ: begin
        if (stat.read_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/rbf_dpath.sv -----
// ----------------------------------------------------------------------------
// rbf_dpath
// Slot memory, pointers, counters, block state and the result registers.
// ----------------------------------------------------------------------------
module rbf_dpath #(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rbf_pkg::rbf_cmd_t               cmd,
  output rbf_pkg::rbf_stat_t              stat,
  input  logic [rbf_pkg::OP_W-1:0]        in_op,
  input  logic [rbf_pkg::CNT_W-1:0]       in_count,
  input  logic [rbf_pkg::DATA_W-1:0]      in_data,
  input  logic [rbf_pkg::CNT_W-1:0]       cfg_data,
  output logic                            out_valid,
  output logic [rbf_pkg::STATUS_W-1:0]    out_status,
  output logic [rbf_pkg::DATA_W-1:0]      out_read_data,
  output logic                            out_last,
  output logic [rbf_pkg::CNT_W-1:0]       out_used_count,
  output logic [rbf_pkg::CNT_W-1:0]       out_free_count
);
  import rbf_pkg::*;

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  // Slot memory
  logic [ELEM_WIDTH-1:0] mem [DEPTH];
  logic [ELEM_WIDTH-1:0] mem_rdata_r;

  // Control state
  logic [PTR_W-1:0]  rp_r,     rp_nxt;
  logic [PTR_W-1:0]  wp_r,     wp_nxt;
  logic [FILL_W-1:0] fill_r,   fill_nxt;
  logic [FILL_W-1:0] cap_r,    cap_nxt;
  logic [CNT_W-1:0]  brem_r,   brem_nxt;
  logic              bdisc_r,  bdisc_nxt;
  logic [FILL_W-1:0] rdleft_r, rdleft_nxt;

  // Result registers
  logic                out_valid_r,  out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_last_r,   out_last_nxt;
  logic                out_mem_r,    out_mem_nxt;
  logic [FILL_W-1:0]   out_used_r,   out_used_nxt;
  logic [FILL_W-1:0]   out_free_r,   out_free_nxt;

  // Memory port controls
  logic                  mem_we;
  logic [PTR_W-1:0]      mem_waddr;
  logic                  mem_re;
  logic [ELEM_WIDTH+DATA_W-1:0] wdata_ext;
  logic [ELEM_WIDTH+DATA_W-1:0] rdata_ext;

  logic [CNT_W-1:0] cap_w;
  logic [CNT_W-1:0] fill_w;
  logic [CNT_W-1:0] brem_dec;

  // Step a pointer around the ring of cap_r slots
  function automatic logic [PTR_W-1:0] ring_adv(input logic [PTR_W-1:0] p,
                                               input logic [FILL_W-1:0] cap);
    logic [FILL_W-1:0] pn;
    pn = FILL_W'(p) + FILL_W'(1);
    return (pn >= cap) ? '0 : pn[PTR_W-1:0];
  endfunction

  assign wdata_ext = {{ELEM_WIDTH{1'b0}}, in_data};
  assign rdata_ext = {{DATA_W{1'b0}}, mem_rdata_r};
  assign cap_w     = CNT_W'(cap_r);
  assign fill_w    = CNT_W'(fill_r);
  assign brem_dec  = brem_r - CNT_W'(1);

  // Tell the controller when a read sequence starts and ends
  always_comb begin
    stat.read_go   = 1'b0;
    stat.read_last = (rdleft_r == FILL_W'(1));
    if (in_op == OP_READ) begin
      stat.read_go = (fill_r != '0);
    end else if (in_op == OP_READ_BLK) begin
      stat.read_go = (in_count != '0) && (in_count <= fill_w);
    end
  end

  // Clamp the capacity write into the usable range
  always_comb begin
    if (cfg_data == '0) begin
      cap_nxt = FILL_W'(1);
    end else if (cfg_data > CNT_W'(DEPTH)) begin
      cap_nxt = FILL_W'(DEPTH);
    end else begin
      cap_nxt = FILL_W'(cfg_data);
    end
  end

  // Execute ops, step reads, empty on capacity writes
  always_comb begin
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    brem_nxt      = brem_r;
    bdisc_nxt     = bdisc_r;
    rdleft_nxt    = rdleft_r;
    out_valid_nxt = 1'b0;
    out_status_nxt = STAT_OK;
    out_last_nxt  = 1'b1;
    out_mem_nxt   = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = wp_r;
    mem_re        = 1'b0;

    if (cmd.cfg_write) begin
      rp_nxt    = '0;
      wp_nxt    = '0;
      fill_nxt  = '0;
      brem_nxt  = '0;
      bdisc_nxt = 1'b0;
    end else if (cmd.exec) begin
      out_valid_nxt = 1'b1;
      // any op but block data drops a pending block
      if (in_op != OP_BLK_DATA) begin
        brem_nxt  = '0;
        bdisc_nxt = 1'b0;
      end
      case (in_op)
        OP_WRITE: begin
          mem_we = 1'b1;
          wp_nxt = ring_adv(wp_r, cap_r);
          if (fill_r >= cap_r) begin
            rp_nxt         = wp_nxt;
            out_status_nxt = STAT_OVERWROTE;
          end else begin
            fill_nxt = fill_r + FILL_W'(1);
          end
        end
        OP_BLK_HEAD: begin
          if (in_count == '0) begin
            out_status_nxt = STAT_OK;
          end else if (in_count <= cap_w - fill_w) begin
            mem_we   = 1'b1;
            wp_nxt   = ring_adv(wp_r, cap_r);
            fill_nxt = fill_r + FILL_W'(1);
            brem_nxt = in_count - CNT_W'(1);
          end else begin
            brem_nxt       = in_count - CNT_W'(1);
            bdisc_nxt      = (in_count != CNT_W'(1));
            out_status_nxt = STAT_NOROOM;
          end
        end
        OP_BLK_DATA: begin
          if (brem_r == '0 || bdisc_r) begin
            if (brem_r != '0) brem_nxt = brem_dec;
            if (brem_r == '0 || brem_dec == '0) bdisc_nxt = 1'b0;
            out_status_nxt = STAT_DISCARD;
          end else if (fill_r >= cap_r) begin
            brem_nxt       = brem_dec;
            out_status_nxt = STAT_NOROOM;
          end else begin
            mem_we   = 1'b1;
            wp_nxt   = ring_adv(wp_r, cap_r);
            fill_nxt = fill_r + FILL_W'(1);
            brem_nxt = brem_dec;
          end
        end
        OP_READ: begin
          if (fill_r == '0) begin
            out_status_nxt = STAT_SHORT;
          end else begin
            out_valid_nxt = 1'b0;
            rdleft_nxt    = FILL_W'(1);
          end
        end
        OP_READ_BLK: begin
          if (in_count == '0) begin
            out_status_nxt = STAT_OK;
          end else if (in_count > fill_w) begin
            out_status_nxt = STAT_SHORT;
          end else begin
            out_valid_nxt = 1'b0;
            rdleft_nxt    = FILL_W'(in_count);
          end
        end
        default: out_status_nxt = STAT_OK;
      endcase
    end else if (cmd.read_step) begin
      mem_re        = 1'b1;
      rp_nxt        = ring_adv(rp_r, cap_r);
      fill_nxt      = fill_r - FILL_W'(1);
      rdleft_nxt    = rdleft_r - FILL_W'(1);
      out_valid_nxt = 1'b1;
      out_mem_nxt   = 1'b1;
      out_last_nxt  = stat.read_last;
    end

    out_used_nxt = fill_nxt;
    out_free_nxt = cap_r - fill_nxt;
  end

  // Slot memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= wdata_ext[ELEM_WIDTH-1:0];
    if (mem_re) mem_rdata_r <= mem[rp_r];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r        <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      cap_r       <= FILL_W'(DEPTH);
      brem_r      <= '0;
      bdisc_r     <= 1'b0;
      rdleft_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      if (cmd.cfg_write) cap_r <= cap_nxt;
      brem_r      <= brem_nxt;
      bdisc_r     <= bdisc_nxt;
      rdleft_r    <= rdleft_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    out_mem_r    <= out_mem_nxt;
    out_used_r   <= out_used_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;
  assign out_used_count = CNT_W'(out_used_r);
  assign out_free_count = CNT_W'(out_free_r);
  assign out_read_data  = out_mem_r ? rdata_ext[DATA_W-1:0] : '0;

endmodule
